### design/ddmc_pkg.sv
// types, codes and constants shared by the drive command unit
`default_nettype none
package ddmc_pkg;

    typedef struct packed {
        logic [2:0]        op;
        logic [7:0]        key;
        logic signed [7:0] left_cmd;
        logic signed [7:0] right_cmd;
        logic [7:0]        hold_time;
    } t_in_item;

    typedef struct packed {
        logic              left_forward;
        logic              right_forward;
        logic [19:0]       left_width;
        logic [19:0]       right_width;
        logic signed [7:0] left_rec_spd;
        logic signed [7:0] right_rec_spd;
        logic              timed_active;
    } t_out_item;

    // stage loads handed to the width datapath
    typedef struct packed {
        logic s2;
        logic s3;
        logic so;
    } t_stage_load;

    // applied drive levels and status after the last transaction
    typedef struct packed {
        logic signed [7:0] drive_left;
        logic signed [7:0] drive_right;
        logic signed [7:0] rec_left;
        logic signed [7:0] rec_right;
        logic              timed;
    } t_drive_status;

    typedef enum logic [2:0] {
        OP_KEYPAD    = 3'd0,
        OP_DIRECT    = 3'd1,
        OP_BASE_UP   = 3'd2,
        OP_BASE_DOWN = 3'd3,
        OP_TICK      = 3'd4
    } t_op;

    localparam logic [7:0] KEY_1     = 8'h31;
    localparam logic [7:0] KEY_2     = 8'h32;
    localparam logic [7:0] KEY_3     = 8'h33;
    localparam logic [7:0] KEY_4     = 8'h34;
    localparam logic [7:0] KEY_5     = 8'h35;
    localparam logic [7:0] KEY_6     = 8'h36;
    localparam logic [7:0] KEY_7     = 8'h37;
    localparam logic [7:0] KEY_8     = 8'h38;
    localparam logic [7:0] KEY_9     = 8'h39;
    localparam logic [7:0] KEY_SPIN_L = 8'h2E;
    localparam logic [7:0] KEY_SPIN_R = 8'h30;

    localparam logic [6:0]  BASE_RESET = 7'd50;
    localparam logic [6:0]  BASE_MAX   = 7'd95;
    localparam logic [6:0]  BASE_MIN   = 7'd35;
    localparam logic [6:0]  BASE_STEP  = 7'd5;
    localparam logic [8:0]  DRIFT_OFS  = 9'd15;
    localparam logic [8:0]  TURN_OFS   = 9'd30;
    localparam logic [11:0] SPIN_MS    = 12'd200;
    localparam logic [6:0]  DUTY_MAX   = 7'd100;
    localparam logic [19:0] PERIOD_RESET = 20'd100000;

    // floor(2^32 / 100); quotient estimate is low by at most one
    localparam logic [25:0] DIV_RECIP = 26'd42949672;

endpackage
`default_nettype wire

### design/ddmc_ctrl.sv
// command decode and drive state, doubles as the first pipeline stage
`default_nettype none
module ddmc_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire ddmc_pkg::t_in_item     i_item,
    output ddmc_pkg::t_drive_status     o_status
);
    import ddmc_pkg::*;

    logic [6:0]        r_base, n_base;
    logic signed [7:0] r_drv_l, n_drv_l;
    logic signed [7:0] r_drv_r, n_drv_r;
    logic signed [7:0] r_rec_l, n_rec_l;
    logic signed [7:0] r_rec_r, n_rec_r;
    logic [11:0]       r_cd, n_cd;

    always_comb begin
        logic signed [8:0] b;
        logic signed [8:0] l;
        logic signed [8:0] r;
        logic              spin;
        b       = signed'({2'b00, r_base});
        l       = '0;
        r       = '0;
        spin    = 1'b0;
        n_base  = r_base;
        n_drv_l = r_drv_l;
        n_drv_r = r_drv_r;
        n_rec_l = r_rec_l;
        n_rec_r = r_rec_r;
        n_cd    = r_cd;
        unique case (i_item.op)
            OP_KEYPAD: begin
                unique case (i_item.key)
                    KEY_7: begin
                        l = b - signed'(DRIFT_OFS);
                        r = b + signed'(DRIFT_OFS);
                    end
                    KEY_8: begin
                        l = b;
                        r = b;
                    end
                    KEY_9: begin
                        l = b + signed'(DRIFT_OFS);
                        r = b - signed'(DRIFT_OFS);
                    end
                    KEY_4: begin
                        l = b - signed'(TURN_OFS);
                        r = b + signed'(TURN_OFS);
                    end
                    KEY_6: begin
                        l = b + signed'(TURN_OFS);
                        r = b - signed'(TURN_OFS);
                    end
                    KEY_1: begin
                        l = signed'(TURN_OFS) - b;
                        r = -(b + signed'(TURN_OFS));
                    end
                    KEY_2: begin
                        l = -b;
                        r = -b;
                    end
                    KEY_3: begin
                        l = -(b + signed'(TURN_OFS));
                        r = signed'(TURN_OFS) - b;
                    end
                    KEY_SPIN_L: begin
                        spin = 1'b1;
                        l    = -b;
                        r    = b;
                    end
                    KEY_SPIN_R: begin
                        spin = 1'b1;
                        l    = b;
                        r    = -b;
                    end
                    KEY_5: begin
                        l = '0;
                        r = '0;
                    end
                    default: begin
                        l = '0;
                        r = '0;
                    end
                endcase
                n_drv_l = l[7:0];
                n_drv_r = r[7:0];
                if (spin) begin
                    // spin runs on a timer, recorded speed reads as stopped
                    n_rec_l = '0;
                    n_rec_r = '0;
                    n_cd    = SPIN_MS;
                end else begin
                    n_rec_l = l[7:0];
                    n_rec_r = r[7:0];
                    n_cd    = '0;
                end
            end
            OP_DIRECT: begin
                n_drv_l = i_item.left_cmd;
                n_drv_r = i_item.right_cmd;
                n_rec_l = i_item.left_cmd;
                n_rec_r = i_item.right_cmd;
                // hold times ten
                n_cd = ({4'b0, i_item.hold_time} << 3) + ({4'b0, i_item.hold_time} << 1);
            end
            OP_BASE_UP: begin
                n_base = (r_base >= BASE_MAX - BASE_STEP) ? BASE_MAX : r_base + BASE_STEP;
            end
            OP_BASE_DOWN: begin
                n_base = (r_base <= BASE_MIN + BASE_STEP) ? BASE_MIN : r_base - BASE_STEP;
            end
            OP_TICK: begin
                if (r_cd != '0) begin
                    n_cd = r_cd - 12'd1;
                    if (r_cd == 12'd1) begin
                        n_drv_l = '0;
                        n_drv_r = '0;
                        n_rec_l = '0;
                        n_rec_r = '0;
                    end
                end
            end
            default: begin
                n_base = r_base;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_drv_l <= '0;
            r_drv_r <= '0;
            r_rec_l <= '0;
            r_rec_r <= '0;
            r_cd    <= '0;
        end else if (i_accept) begin
            r_base  <= n_base;
            r_drv_l <= n_drv_l;
            r_drv_r <= n_drv_r;
            r_rec_l <= n_rec_l;
            r_rec_r <= n_rec_r;
            r_cd    <= n_cd;
        end
    end

    assign o_status.drive_left  = r_drv_l;
    assign o_status.drive_right = r_drv_r;
    assign o_status.rec_left    = r_rec_l;
    assign o_status.rec_right   = r_rec_r;
    assign o_status.timed       = (r_cd != '0);

endmodule
`default_nettype wire

### design/ddmc_width.sv
// one wheel: direction, duty clamp and pwm width over three stages
`default_nettype none
module ddmc_width (
    input  wire logic                  i_clk,
    input  wire ddmc_pkg::t_stage_load i_load,
    input  wire logic signed [7:0]     i_level,
    input  wire logic [19:0]           i_period,
    output logic                       o_forward,
    output logic [19:0]                o_width
);
    import ddmc_pkg::*;

    logic [8:0]  w_abs;
    logic [6:0]  w_mag;
    logic [51:0] w_recip_prod;
    logic [26:0] w_qx100;
    logic [26:0] w_rem;
    logic [19:0] w_width;

    logic        r_fwd2, r_fwd3, r_fwd_o;
    logic [26:0] r_prod2, r_prod3;
    logic [19:0] r_q3;
    logic [19:0] r_width_o;

    // magnitude clamped to 1..100
    always_comb begin
        w_abs = i_level[7] ? 9'(-{i_level[7], i_level}) : {1'b0, i_level};
        if (w_abs > {2'b00, DUTY_MAX}) begin
            w_mag = DUTY_MAX;
        end else if (w_abs == '0) begin
            w_mag = 7'd1;
        end else begin
            w_mag = w_abs[6:0];
        end
    end

    assign w_recip_prod = 52'(r_prod2) * 52'(DIV_RECIP);

    // exact floor by one remainder check
    assign w_qx100 = ({7'b0, r_q3} << 6) + ({7'b0, r_q3} << 5) + ({7'b0, r_q3} << 2);
    assign w_rem   = r_prod3 - w_qx100;
    assign w_width = (w_rem >= 27'(DUTY_MAX)) ? r_q3 + 20'd1 : r_q3;

    always_ff @(posedge i_clk) begin
        if (i_load.s2) begin
            r_fwd2  <= ~i_level[7];
            r_prod2 <= {7'b0, i_period} * {20'b0, w_mag};
        end
        if (i_load.s3) begin
            r_fwd3  <= r_fwd2;
            r_prod3 <= r_prod2;
            r_q3    <= w_recip_prod[51:32];
        end
        if (i_load.so) begin
            r_fwd_o   <= r_fwd3;
            r_width_o <= w_width;
        end
    end

    assign o_forward = r_fwd_o;
    assign o_width   = r_width_o;

endmodule
`default_nettype wire

### design/diff_drive_motor_command.sv
// top level of the two-wheel drive command unit
// Takes keypad, direct-speed, base-step and millisecond-tick transactions and
// returns one status transaction for each: per wheel a direction bit and a PWM
// high width of period*duty/100 with duty clamped to 1..100, the recorded
// speeds and whether a timed stop is counting down. One transaction is taken
// per clock; its result passes through command decode, width product,
// reciprocal quotient estimate and remainder correction before it is valid on
// the status channel, and the pipeline keeps taking transactions as long as
// results are drained. The pwm_period register is written over its own
// channel, which is always ready, and must only be written while no transaction
// is in flight.
`default_nettype none
module diff_drive_motor_command (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ddmc_pkg::t_in_item   i_in_item,
    // status channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ddmc_pkg::t_out_item       o_out_item,
    // pwm_period write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [19:0]          i_cfg_data
);
    import ddmc_pkg::*;

    logic [19:0]   r_pwm_period;
    t_drive_status w_status;
    t_stage_load   w_load;
    logic          w_accept;

    // stage valids: v1 is the state register itself, vo is the result register
    logic r_v1, r_v2, r_v3, r_vo;

    // sideband status carried alongside the width datapath
    logic signed [7:0] r_spd_l2, r_spd_r2, r_spd_l3, r_spd_r3, r_spd_lo, r_spd_ro;
    logic              r_tmd2, r_tmd3, r_tmdo;

    logic w_fwd_l, w_fwd_r;
    logic [19:0] w_wid_l, w_wid_r;

    // ready chain from the result register back to the command channel
    assign w_load.so = r_v3 && (!r_vo || i_out_ready);
    assign w_load.s3 = r_v2 && (!r_v3 || w_load.so);
    assign w_load.s2 = r_v1 && (!r_v2 || w_load.s3);
    assign o_in_ready = !r_v1 || w_load.s2;
    assign w_accept   = i_in_valid && o_in_ready;

    // config write, always taken
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_pwm_period <= i_cfg_data;
        end
    end

    // state update on every accepted transaction
    ddmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_status (w_status)
    );

    ddmc_width u_width_l (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_level   (w_status.drive_left),
        .i_period  (r_pwm_period),
        .o_forward (w_fwd_l),
        .o_width   (w_wid_l)
    );

    ddmc_width u_width_r (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_level   (w_status.drive_right),
        .i_period  (r_pwm_period),
        .o_forward (w_fwd_r),
        .o_width   (w_wid_r)
    );

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_load.s2) begin
                r_v1 <= 1'b0;
            end
            if (w_load.s2) begin
                r_v2 <= 1'b1;
            end else if (w_load.s3) begin
                r_v2 <= 1'b0;
            end
            if (w_load.s3) begin
                r_v3 <= 1'b1;
            end else if (w_load.so) begin
                r_v3 <= 1'b0;
            end
            if (w_load.so) begin
                r_vo <= 1'b1;
            end else if (i_out_ready) begin
                r_vo <= 1'b0;
            end
        end
    end

    // sideband payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load.s2) begin
            r_spd_l2 <= w_status.rec_left;
            r_spd_r2 <= w_status.rec_right;
            r_tmd2   <= w_status.timed;
        end
        if (w_load.s3) begin
            r_spd_l3 <= r_spd_l2;
            r_spd_r3 <= r_spd_r2;
            r_tmd3   <= r_tmd2;
        end
        if (w_load.so) begin
            r_spd_lo <= r_spd_l3;
            r_spd_ro <= r_spd_r3;
            r_tmdo   <= r_tmd3;
        end
    end

    assign o_out_valid              = r_vo;
    assign o_out_item.left_forward  = w_fwd_l;
    assign o_out_item.right_forward = w_fwd_r;
    assign o_out_item.left_width    = w_wid_l;
    assign o_out_item.right_width   = w_wid_r;
    assign o_out_item.left_rec_spd  = r_spd_lo;
    assign o_out_item.right_rec_spd = r_spd_ro;
    assign o_out_item.timed_active  = r_tmdo;

endmodule
`default_nettype wire

### tb/sv/tb_diff_drive_motor_command.sv
// testbench for the two-wheel drive command unit: directed table, then random phases
`timescale 1ns / 100ps
module tb_diff_drive_motor_command;
    import ddmc_pkg::*;

    // one line of the directed table
    typedef struct packed {
        t_in_item   item;
        logic [7:0] reps;
        logic       typed;
        t_out_item  want;
    } t_plan_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data  = '0;

    // drive model state
    logic [19:0] period_now;
    int          base_lvl;
    int          rec_l;
    int          rec_r;
    int          lvl_l;
    int          lvl_r;
    int          stop_ms;

    t_out_item   status_pending[$];
    t_plan_row   plan[$];
    int          mismatch_count = 0;
    int          issued         = 0;
    bit          stall_enable   = 1'b1;

    diff_drive_motor_command dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // pwm high width for one wheel level, duty clamped to 1..100
    function automatic logic [19:0] pwm_width(int level);
        int     mag;
        longint prod;
        mag = (level < 0) ? -level : level;
        if (mag > int'(DUTY_MAX)) mag = int'(DUTY_MAX);
        if (mag < 1) mag = 1;
        prod = longint'(period_now) * mag / int'(DUTY_MAX);
        return prod[19:0];
    endfunction

    // advance the drive model by one command and return the status it reports
    function automatic t_out_item drive_predict(t_in_item it);
        t_out_item o;
        int        b;
        int        l;
        int        r;
        int        drift;
        int        turn;
        bit        spin;
        b     = base_lvl;
        drift = int'(DRIFT_OFS);
        turn  = int'(TURN_OFS);
        l     = 0;
        r     = 0;
        spin  = 1'b0;
        case (it.op)
            OP_KEYPAD: begin
                stop_ms = 0;
                case (it.key)
                    KEY_7: begin l = b - drift; r = b + drift; end
                    KEY_8: begin l = b; r = b; end
                    KEY_9: begin l = b + drift; r = b - drift; end
                    KEY_4: begin l = b - turn; r = b + turn; end
                    KEY_6: begin l = b + turn; r = b - turn; end
                    KEY_5: ;
                    KEY_1: begin l = -(b - turn); r = -(b + turn); end
                    KEY_2: begin l = -b; r = -b; end
                    KEY_3: begin l = -(b + turn); r = -(b - turn); end
                    KEY_SPIN_L, KEY_SPIN_R: spin = 1'b1;
                    default: ;  // unknown key stops both wheels
                endcase
                if (spin) begin
                    lvl_l   = (it.key == KEY_SPIN_L) ? -b : b;
                    lvl_r   = -lvl_l;
                    rec_l   = 0;
                    rec_r   = 0;
                    stop_ms = int'(SPIN_MS);
                end else begin
                    lvl_l = l;
                    lvl_r = r;
                    rec_l = l;
                    rec_r = r;
                end
            end
            OP_DIRECT: begin
                rec_l   = $signed(it.left_cmd);
                rec_r   = $signed(it.right_cmd);
                lvl_l   = rec_l;
                lvl_r   = rec_r;
                stop_ms = int'(it.hold_time) * 10;
            end
            OP_BASE_UP: begin
                base_lvl = b + int'(BASE_STEP);
                if (base_lvl > int'(BASE_MAX)) base_lvl = int'(BASE_MAX);
            end
            OP_BASE_DOWN: begin
                base_lvl = b - int'(BASE_STEP);
                if (base_lvl < int'(BASE_MIN)) base_lvl = int'(BASE_MIN);
            end
            OP_TICK: begin
                if (stop_ms != 0) begin
                    stop_ms--;
                    // timed stop reached
                    if (stop_ms == 0) begin
                        lvl_l = 0;
                        lvl_r = 0;
                        rec_l = 0;
                        rec_r = 0;
                    end
                end
            end
            default: ;  // unused op only reports status
        endcase
        o.left_forward  = (lvl_l >= 0);
        o.right_forward = (lvl_r >= 0);
        o.left_width    = pwm_width(lvl_l);
        o.right_width   = pwm_width(lvl_r);
        o.left_rec_spd  = 8'(rec_l);
        o.right_rec_spd = 8'(rec_r);
        o.timed_active  = (stop_ms != 0);
        return o;
    endfunction

    function automatic t_in_item mk_item(logic [2:0] op, logic [7:0] key, int l, int r,
                                         int hold);
        t_in_item it;
        it.op        = op;
        it.key       = key;
        it.left_cmd  = 8'(l);
        it.right_cmd = 8'(r);
        it.hold_time = 8'(hold);
        return it;
    endfunction

    function automatic t_out_item mk_status(bit fl, bit fr, int wl, int wr, int sl, int sr,
                                            bit ta);
        t_out_item o;
        o.left_forward  = fl;
        o.right_forward = fr;
        o.left_width    = 20'(wl);
        o.right_width   = 20'(wr);
        o.left_rec_spd  = 8'(sl);
        o.right_rec_spd = 8'(sr);
        o.timed_active  = ta;
        return o;
    endfunction

    function automatic t_plan_row plan_row(t_in_item it, int reps);
        t_plan_row p;
        p.item  = it;
        p.reps  = 8'(reps);
        p.typed = 1'b0;
        p.want  = '0;
        return p;
    endfunction

    function automatic t_plan_row plan_typed(t_in_item it, t_out_item want);
        t_plan_row p;
        p       = plan_row(it, 1);
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    // all fields random, op over its whole 3-bit range
    function automatic t_in_item rand_item();
        t_in_item it;
        it.op        = 3'($urandom_range(0, 7));
        it.key       = 8'($urandom_range(0, 255));
        it.left_cmd  = 8'($urandom_range(0, 255));
        it.right_cmd = 8'($urandom_range(0, 255));
        it.hold_time = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic signed [31:0] got,
                               logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // present one command transaction, hold it until taken, then record its expected status
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        t_out_item pred;
        @(negedge clk);
        while (stall_enable && $urandom_range(0, 99) < 20) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        forever begin
            @(posedge clk);
            if (in_ready) break;
        end
        pred = drive_predict(it);
        status_pending.push_back(typed ? want : pred);
        issued++;
    endtask

    task automatic send_ticks(int n);
        t_in_item it;
        repeat (n) begin
            it    = rand_item();
            it.op = OP_TICK;
            send_item(it, 1'b0, '0);
        end
    endtask

    // register write only once the pipeline has drained
    task automatic write_period(logic [19:0] p);
        @(negedge clk);
        in_valid = 1'b0;
        while (status_pending.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = p;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        period_now = p;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random command sequences: drives, timed holds followed by tick bursts, base steps
    task automatic run_phase(int quota);
        int        stop_at;
        int        pick;
        int        hold;
        t_in_item  it;
        logic [7:0] pad_keys[11];
        pad_keys = '{KEY_1, KEY_2, KEY_3, KEY_4, KEY_5, KEY_6, KEY_7, KEY_8, KEY_9,
                     KEY_SPIN_L, KEY_SPIN_R};
        stop_at = issued + quota;
        while (issued < stop_at) begin
            pick = $urandom_range(0, 99);
            it   = rand_item();
            if (pick < 30) begin
                it.op = OP_KEYPAD;
                if ($urandom_range(0, 9) < 8) it.key = pad_keys[$urandom_range(0, 10)];
                send_item(it, 1'b0, '0);
                // now and then let a spin run out to its stop
                if ((it.key == KEY_SPIN_L || it.key == KEY_SPIN_R) &&
                    $urandom_range(0, 4) == 0)
                    send_ticks($urandom_range(199, 202));
                else
                    send_ticks($urandom_range(0, 5));
            end else if (pick < 55) begin
                it.op = OP_DIRECT;
                hold  = $urandom_range(0, 99);
                if (hold < 40)      it.hold_time = 8'd0;
                else if (hold < 85) it.hold_time = 8'($urandom_range(1, 3));
                send_item(it, 1'b0, '0);
                if (it.hold_time <= 3)
                    send_ticks($urandom_range(0, int'(it.hold_time) * 10 + 3));
                else
                    send_ticks($urandom_range(0, 20));
            end else if (pick < 70) begin
                hold = $urandom_range(1, 12);
                repeat (hold) begin
                    it    = rand_item();
                    it.op = ($urandom_range(0, 1) != 0) ? OP_BASE_UP : OP_BASE_DOWN;
                    send_item(it, 1'b0, '0);
                end
            end else if (pick < 92) begin
                send_ticks($urandom_range(1, 8));
            end else begin
                it.op = 3'($urandom_range(5, 7));
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    // receiver stalls at random
    always @(negedge clk)
        out_ready = !(stall_enable && $urandom_range(0, 99) < 20);

    // status checker against the oldest pending expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (status_pending.size() == 0) begin
                report_mismatch("status transaction with nothing pending");
            end else begin
                want = status_pending.pop_front();
                check_field("left_forward", out_item.left_forward, want.left_forward);
                check_field("right_forward", out_item.right_forward, want.right_forward);
                check_field("left_width", out_item.left_width, want.left_width);
                check_field("right_width", out_item.right_width, want.right_width);
                check_field("left_rec_spd", out_item.left_rec_spd, want.left_rec_spd);
                check_field("right_rec_spd", out_item.right_rec_spd, want.right_rec_spd);
                check_field("timed_active", out_item.timed_active, want.timed_active);
            end
        end
    end

    initial begin
        logic [19:0] periods[6];
        period_now = PERIOD_RESET;
        base_lvl   = int'(BASE_RESET);
        rec_l      = 0;
        rec_r      = 0;
        lvl_l      = 0;
        lvl_r      = 0;
        stop_ms    = 0;

        // after reset: period 100000, base 50
        plan.push_back(plan_typed(mk_item(OP_TICK, 8'h00, 0, 0, 0),
                                  mk_status(1, 1, 1000, 1000, 0, 0, 0)));
        plan.push_back(plan_typed(mk_item(OP_DIRECT, 8'h00, 127, -128, 0),
                                  mk_status(1, 0, 100000, 100000, 127, -128, 0)));
        plan.push_back(plan_typed(mk_item(OP_DIRECT, 8'h00, -1, 1, 0),
                                  mk_status(0, 1, 1000, 1000, -1, 1, 0)));
        plan.push_back(plan_typed(mk_item(OP_KEYPAD, 8'hFF, 0, 0, 0),
                                  mk_status(1, 1, 1000, 1000, 0, 0, 0)));
        plan.push_back(plan_typed(mk_item(OP_KEYPAD, KEY_8, 0, 0, 0),
                                  mk_status(1, 1, 50000, 50000, 50, 50, 0)));
        // the rest of the keypad table
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_7, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_9, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_4, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_6, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_1, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_2, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_3, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_5, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, 8'h00, 0, 0, 0), 1));
        // spin, base step keeps the countdown, second spin restarts it
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_SPIN_L, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_BASE_UP, 8'h00, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_TICK, 8'h00, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_SPIN_R, 0, 0, 0), 1));
        // shortest timed hold runs out on its tenth tick
        plan.push_back(plan_row(mk_item(OP_DIRECT, 8'h00, 100, -100, 1), 1));
        plan.push_back(plan_row(mk_item(OP_TICK, 8'h00, 0, 0, 0), 10));
        // longest hold, cancelled by a keypad command, then an idle tick
        plan.push_back(plan_row(mk_item(OP_DIRECT, 8'h00, -128, 127, 255), 1));
        plan.push_back(plan_row(mk_item(OP_TICK, 8'h00, 0, 0, 0), 2));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_2, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_TICK, 8'h00, 0, 0, 0), 1));
        // base saturation at both ends, with drives past the duty limit
        plan.push_back(plan_row(mk_item(OP_BASE_UP, 8'h00, 0, 0, 0), 9));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_3, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_6, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_BASE_DOWN, 8'h00, 0, 0, 0), 13));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_1, 0, 0, 0), 1));
        plan.push_back(plan_row(mk_item(OP_KEYPAD, KEY_4, 0, 0, 0), 1));
        // unused ops
        plan.push_back(plan_row(mk_item(3'd5, 8'h38, 1, 1, 1), 1));
        plan.push_back(plan_row(mk_item(3'd7, 8'hFF, -1, -1, 255), 1));

        periods[0] = 20'hFFFFF;
        periods[1] = 20'd1;
        periods[2] = 20'd0;
        periods[3] = 20'($urandom_range(2, 1048574));
        periods[4] = PERIOD_RESET;
        periods[5] = 20'($urandom_range(1, 1048575));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            repeat (plan[i].reps) send_item(plan[i].item, plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            // one phase runs with no stalls on either side
            stall_enable = (ph != 3);
            write_period(periods[ph]);
            run_phase(230);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (status_pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("diff_drive_motor_command test passed");
        else
            $display("diff_drive_motor_command test failed");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("diff_drive_motor_command test failed");
        $finish;
    end

endmodule

### sim.f
design/ddmc_pkg.sv
design/ddmc_ctrl.sv
design/ddmc_width.sv
design/diff_drive_motor_command.sv
tb/sv/tb_diff_drive_motor_command.sv
